### sv/wfop_pkg.sv
package wfop_pkg;

    localparam int MAX_DIM = 8;
    localparam int NUM_FACTORS = 4;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int SEL_W = $clog2(NUM_FACTORS);
    localparam int TDEPTH = MAX_DIM * MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W = 12;
    localparam int VAL_W = 32;
    localparam int ACC_W = 48;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SIZE_W = 4;
    localparam int REQ_W = 3;
    localparam int CFG_IDX_W = 4;

    localparam logic [REQ_W-1:0] REQ_LOAD_FACTOR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_WEIGHT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ACCUMULATE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ        = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SECOND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_THIRD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FOURTH = 4'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    typedef struct packed {
        logic [REQ_W-1:0]         op;
        logic [SEL_W-1:0]         sel;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  value;
        logic [ADDR_W-1:0]        addr;
    } t_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0] first;
        logic [SIZE_W-1:0] second;
        logic [SIZE_W-1:0] third;
        logic [SIZE_W-1:0] fourth;
    } t_sizes;

    typedef struct packed {
        logic pop;
        logic init_busy;
        logic acc_busy;
        logic rd_issue;
    } t_back_stat;

    function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] e;
        if (s == '0) begin
            e = SIZE_W'(1);
        end else if (s > SIZE_W'(MAX_DIM)) begin
            e = SIZE_W'(MAX_DIM);
        end else begin
            e = s;
        end
        return IDX_W'(e - SIZE_W'(1));
    endfunction

    function automatic logic signed [VAL_W-1:0] qround(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = (p + PROD_W'(32768)) >>> 16;
        if (s > PROD_W'(64'sh7FFF_FFFF)) begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end else if (s < -PROD_W'(64'sh8000_0000)) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [VAL_W-1:0] t
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(t);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

### sv/wfop_in_if.sv
interface wfop_in_if;
    import wfop_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [SEL_W-1:0]         factor_select;
    logic [IDX_W-1:0]         element_index;
    logic signed [VAL_W-1:0]  sample_value;
    logic [ADDR_W-1:0]        entry_address;

    modport source (output valid, req_type, factor_select, element_index, sample_value,
                    entry_address, input ready);
    modport sink (input valid, req_type, factor_select, element_index, sample_value,
                  entry_address, output ready);
endinterface

### sv/wfop_out_if.sv
interface wfop_out_if;
    import wfop_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  entry_value;
    logic [ADDR_W-1:0]        entry_address_out;

    modport source (output valid, entry_value, entry_address_out, input ready);
    modport sink (input valid, entry_value, entry_address_out, output ready);
endinterface

### sv/wfop_cfg_if.sv
interface wfop_cfg_if;
    import wfop_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [SIZE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/wfop_ram.sv
module wfop_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

### sv/wfop_front.sv
module wfop_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    wfop_in_if.sink                 i_in,
    input  wfop_pkg::t_back_stat    i_stat,
    output logic                    o_cmd_valid,
    output wfop_pkg::t_cmd          o_cmd
);
    import wfop_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, known, push;
    t_cmd       cmd_in;

    assign i_in.ready = (r_cnt != 2'd2) && !i_stat.init_busy;
    assign accept = i_in.valid && i_in.ready;
    // unknown requests and out-of-range loads leave no trace
    assign known = (i_in.req_type <= REQ_CLEAR) &&
                   !((i_in.req_type == REQ_LOAD_FACTOR) && (int'(i_in.element_index) >= MAX_DIM));
    assign push = accept && known;

    always_comb begin
        cmd_in.op    = i_in.req_type;
        cmd_in.sel   = i_in.factor_select;
        cmd_in.idx   = i_in.element_index;
        cmd_in.value = i_in.sample_value;
        cmd_in.addr  = i_in.entry_address;
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_stat.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_stat.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end
endmodule

### sv/wfop_back.sv
module wfop_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  wfop_pkg::t_cmd          i_cmd,
    input  wfop_pkg::t_sizes        i_sizes,
    output wfop_pkg::t_back_stat    o_stat,
    wfop_out_if.source              o_out
);
    import wfop_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_CLR   = 3'd4;
    localparam logic [2:0] ST_RDW   = 3'd5;

    logic [2:0] r_state, n_state;

    logic signed [VAL_W-1:0] r_fv [NUM_FACTORS][MAX_DIM];
    logic signed [VAL_W-1:0] r_w;

    logic [IDX_W-1:0]  r_ci, r_cj, r_ck, r_cl;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_rd_addr;

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [VAL_W-1:0]  r_a0, r_b0, r_c0, r_d0, r_w0;
    logic signed [VAL_W-1:0]  r_c1, r_d1, r_w1, r_d2, r_w2, r_w3, r_t5;
    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3, r_p4;
    logic [ADDR_W-1:0] r_ad0, r_ad1, r_ad2, r_ad3, r_ad4, r_ad5;

    logic                    r_out_v;
    logic signed [ACC_W-1:0] r_out_val;
    logic [ADDR_W-1:0]       r_out_addr;

    logic l_last, k_last, j_last, i_last, issue;
    logic pop, rd_issue, clearing;
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ACC_W-1:0]  mem_wdata, mem_rdata;

    assign l_last = (r_cl == last_index(i_sizes.fourth));
    assign k_last = (r_ck == last_index(i_sizes.third));
    assign j_last = (r_cj == last_index(i_sizes.second));
    assign i_last = (r_ci == last_index(i_sizes.first));
    assign issue = (r_state == ST_ACC);
    assign clearing = (r_state == ST_INIT) || (r_state == ST_CLR);

    assign rd_issue = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.op == REQ_READ) && !r_out_v;
    assign pop = (r_state == ST_IDLE) && i_cmd_valid && ((i_cmd.op != REQ_READ) || !r_out_v);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT, ST_CLR: begin
                if (r_addr == ADDR_W'(TDEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.op)
                        REQ_ACCUMULATE: n_state = ST_ACC;
                        REQ_READ:       n_state = ST_RDW;
                        REQ_CLEAR:      n_state = ST_CLR;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ACC: begin
                if (l_last && k_last && j_last && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(r_v0 || r_v1 || r_v2 || r_v3 || r_v4 || r_v5)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDW: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign mem_re = r_v4 || rd_issue;
    assign mem_raddr = r_v4 ? r_ad4 : i_cmd.addr;
    assign mem_we = r_v5 || clearing;
    assign mem_waddr = r_v5 ? r_ad5 : r_addr;
    assign mem_wdata = r_v5 ? sat_add(mem_rdata, r_t5) : '0;

    wfop_ram #(
        .WIDTH (ACC_W),
        .DEPTH (TDEPTH)
    ) u_tensor (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_addr  <= '0;
            r_ci    <= '0;
            r_cj    <= '0;
            r_ck    <= '0;
            r_cl    <= '0;
            r_w     <= '0;
            r_out_v <= 1'b0;
            {r_v0, r_v1, r_v2, r_v3, r_v4, r_v5} <= '0;
        end else begin
            r_state <= n_state;
            {r_v1, r_v2, r_v3, r_v4, r_v5} <= {r_v0, r_v1, r_v2, r_v3, r_v4};
            r_v0 <= issue;
            if (clearing || issue) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (pop && (i_cmd.op == REQ_LOAD_WEIGHT)) begin
                r_w <= i_cmd.value;
            end
            if (pop && ((i_cmd.op == REQ_ACCUMULATE) || (i_cmd.op == REQ_CLEAR))) begin
                r_addr <= '0;
                r_ci   <= '0;
                r_cj   <= '0;
                r_ck   <= '0;
                r_cl   <= '0;
            end
            if (issue) begin
                r_cl <= l_last ? '0 : r_cl + IDX_W'(1);
                if (l_last) begin
                    r_ck <= k_last ? '0 : r_ck + IDX_W'(1);
                    if (k_last) begin
                        r_cj <= j_last ? '0 : r_cj + IDX_W'(1);
                        if (j_last) begin
                            r_ci <= r_ci + IDX_W'(1);
                        end
                    end
                end
            end
            if (r_state == ST_RDW) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_cmd.op == REQ_LOAD_FACTOR)) begin
            r_fv[i_cmd.sel][i_cmd.idx] <= i_cmd.value;
        end
        if (rd_issue) begin
            r_rd_addr <= i_cmd.addr;
        end
        if (r_state == ST_RDW) begin
            r_out_val  <= mem_rdata;
            r_out_addr <= r_rd_addr;
        end
        r_a0  <= r_fv[0][r_ci];
        r_b0  <= r_fv[1][r_cj];
        r_c0  <= r_fv[2][r_ck];
        r_d0  <= r_fv[3][r_cl];
        r_w0  <= r_w;
        r_ad0 <= r_addr;
        r_p1  <= PROD_W'(r_a0) * PROD_W'(r_b0);
        r_c1  <= r_c0;
        r_d1  <= r_d0;
        r_w1  <= r_w0;
        r_ad1 <= r_ad0;
        r_p2  <= PROD_W'(qround(r_p1)) * PROD_W'(r_c1);
        r_d2  <= r_d1;
        r_w2  <= r_w1;
        r_ad2 <= r_ad1;
        r_p3  <= PROD_W'(qround(r_p2)) * PROD_W'(r_d2);
        r_w3  <= r_w2;
        r_ad3 <= r_ad2;
        r_p4  <= PROD_W'(qround(r_p3)) * PROD_W'(r_w3);
        r_ad4 <= r_ad3;
        r_t5  <= qround(r_p4);
        r_ad5 <= r_ad4;
    end

    assign o_out.valid = r_out_v;
    assign o_out.entry_value = r_out_val;
    assign o_out.entry_address_out = r_out_addr;

    always_comb begin
        o_stat.pop       = pop;
        o_stat.init_busy = (r_state == ST_INIT);
        o_stat.acc_busy  = (r_state == ST_ACC) || (r_state == ST_DRAIN);
        o_stat.rd_issue  = rd_issue;
    end
endmodule

### sv/weighted_four_way_outer_product_sum.sv
// weighted four-way outer product sum: T[i,j,k,l] += w*A[i]*B[j]*C[k]*D[l]
// channels: i_in takes request beats (load factor, load weight, accumulate,
// read, clear), o_out returns one beat per read with the entry and its
// address, i_cfg writes the four size registers (index 0..3), always ready
// a front stage decodes beats into a two-entry queue; a back engine runs them
// load beats: written into the factor or weight register when popped by the back engine
// read beats: the ram read issues at the queue head, then ST_RDW loads the output register that drives o_out valid
// accumulate: s1*s2*s3*s4 tensor entries, one per cycle through a six
// stage multiply pipeline on the single tensor ram port pair, then a drain until the pipeline is empty
// clear: all 4096 ram entries, one ram entry zeroed per cycle
// after reset all 4096 tensor ram entries are zeroed; i_in.ready stays low
// during that pass while config writes are still taken
// a read result waits in the output register while o_out.ready is low; the
// queue keeps accepting beats until it holds two, then i_in.ready drops
// sizes of zero act as one and sizes above eight act as eight
module weighted_four_way_outer_product_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfop_in_if.sink     i_in,
    wfop_out_if.source  o_out,
    wfop_cfg_if.sink    i_cfg
);
    import wfop_pkg::*;

    t_sizes     r_sizes;
    t_back_stat stat;
    t_cmd       cmd;
    logic       cmd_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sizes.first  <= SIZE_RESET;
            r_sizes.second <= SIZE_RESET;
            r_sizes.third  <= SIZE_RESET;
            r_sizes.fourth <= SIZE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SIZE_FIRST:  r_sizes.first  <= i_cfg.data;
                CFG_SIZE_SECOND: r_sizes.second <= i_cfg.data;
                CFG_SIZE_THIRD:  r_sizes.third  <= i_cfg.data;
                CFG_SIZE_FOURTH: r_sizes.fourth <= i_cfg.data;
                default: ;
            endcase
        end
    end

    wfop_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_stat      (stat),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    wfop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_sizes     (r_sizes),
        .o_stat      (stat),
        .o_out       (o_out)
    );

    a_init_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.init_busy |-> !o_out.valid)
        else $error("read result during reset clear");

    a_rise_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(stat.rd_issue, 2))
        else $error("result without read issue");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.acc_busy |-> !stat.pop && !stat.rd_issue)
        else $error("queue popped during accumulate");

    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pop |-> cmd_valid)
        else $error("pop from empty queue");
endmodule
